// ===== rtl/core/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 6;
    localparam int DIGITS  = 10;
    localparam int DIGIT_W = 4;
    localparam int POS_W   = $clog2(DIGITS);

    // size mode codes; any other code falls through to the 32-bit mode
    localparam logic [MODE_W-1:0] SIZE_8  = 2'd0;
    localparam logic [MODE_W-1:0] SIZE_16 = 2'd1;

    localparam logic [VALUE_W-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [VALUE_W-1:0] MASK_16 = 32'h0000_FFFF;

    // index of the final character position per mode
    localparam logic [POS_W-1:0] LAST_POS_8  = POS_W'(2);
    localparam logic [POS_W-1:0] LAST_POS_16 = POS_W'(4);
    localparam logic [POS_W-1:0] LAST_POS_32 = POS_W'(DIGITS - 1);

    // v / 10 == (v * RECIP) >> RECIP_SHIFT for every 32-bit v
    localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 PROD_W      = 2 * VALUE_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 6'd32;

    // job queue between the front and the converter
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   last_pos;
        logic               padded;
    } t_job;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        t_digits          dig;
        logic [POS_W-1:0] last_pos;
        logic [POS_W-1:0] first;
        logic             padded;
    } t_conv;

    // handshake between converter and emitter
    typedef struct packed {
        logic full;
        t_conv res;
    } t_conv_out;

endpackage

// ===== rtl/core/bda_if.sv =====
// ----------------------------------------------------------------------------
// bda_if
// Valid/ready channel interfaces for input numbers and output characters.
// ----------------------------------------------------------------------------
interface bda_in_if;
    import bda_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [MODE_W-1:0]  size_mode;

    modport source (output valid, output value, output size_mode, input ready);
    modport sink   (input valid, input value, input size_mode, output ready);
endinterface

interface bda_out_if;
    import bda_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/bda_front.sv =====
// ----------------------------------------------------------------------------
// bda_front
// Accept numbers, mask by size mode and classify width and padding.
// ----------------------------------------------------------------------------
module bda_front (
    bda_in_if.sink        i_in,
    output logic          o_job_valid,
    output bda_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import bda_pkg::*;

    always_comb begin
        o_job_valid = i_in.valid;
        i_in.ready  = i_job_ready;
        case (i_in.size_mode)
            SIZE_8: begin
                o_job.value    = i_in.value & MASK_8;
                o_job.last_pos = LAST_POS_8;
                o_job.padded   = 1'b1;
            end
            SIZE_16: begin
                o_job.value    = i_in.value & MASK_16;
                o_job.last_pos = LAST_POS_16;
                o_job.padded   = 1'b1;
            end
            default: begin
                o_job.value    = i_in.value;
                o_job.last_pos = LAST_POS_32;
                o_job.padded   = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bda_queue.sv =====
// ----------------------------------------------------------------------------
// bda_queue
// Short job queue decoupling the front from the converter.
// ----------------------------------------------------------------------------
module bda_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  bda_pkg::t_job i_push_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output bda_pkg::t_job o_pop_job,
    input  logic          i_pop_ready
);
    import bda_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               push, pop;

    assign o_push_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

// ===== rtl/core/bda_conv.sv =====
// ----------------------------------------------------------------------------
// bda_conv
// Peel decimal digits least significant first, one per cycle, by reciprocal
// multiplication; track the most significant nonzero position.
// ----------------------------------------------------------------------------
module bda_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  bda_pkg::t_job      i_job,
    output logic               o_job_ready,
    output bda_pkg::t_conv_out o_res,
    input  logic               i_load
);
    import bda_pkg::*;

    logic               r_busy, n_busy;
    logic               r_full, n_full;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_W-1:0] r_v;
    t_conv              r_res;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic [DIGIT_W-1:0] quot10_lo;
    logic [DIGIT_W-1:0] digit;
    logic               start;

    // remainder only needs the low four bits of v - 10q
    assign prod      = PROD_W'(r_v) * PROD_W'(RECIP);
    assign quot      = prod[PROD_W-1:RECIP_SHIFT];
    assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign digit     = r_v[DIGIT_W-1:0] - quot10_lo;

    assign o_job_ready = !r_busy && (!r_full || i_load);
    assign start       = i_job_valid && o_job_ready;
    assign o_res.full  = r_full;
    assign o_res.res   = r_res;

    always_comb begin
        n_busy = r_busy;
        n_full = r_full;
        if (i_load) begin
            n_full = 1'b0;
        end
        if (start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_pos == '0) begin
            n_busy = 1'b0;
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_v            <= i_job.value;
            r_pos          <= i_job.last_pos;
            r_res.last_pos <= i_job.last_pos;
            r_res.first    <= i_job.last_pos;
            r_res.padded   <= i_job.padded;
        end else if (r_busy) begin
            r_res.dig[r_pos] <= digit;
            if (digit != '0) begin
                r_res.first <= r_pos;
            end
            r_v <= VALUE_W'(quot);
            if (r_pos != '0) begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/bda_emit.sv =====
// ----------------------------------------------------------------------------
// bda_emit
// Hold one converted number and send its characters, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module bda_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bda_pkg::t_conv_out i_res,
    output logic               o_load,
    bda_out_if.source          o_out
);
    import bda_pkg::*;

    logic             r_act, n_act;
    logic [POS_W-1:0] r_idx;
    t_conv            r_num;
    logic             is_last;
    logic             send;

    assign is_last = (r_idx == r_num.last_pos);
    assign send    = r_act && o_out.ready;
    assign o_load  = i_res.full && (!r_act || (send && is_last));

    always_comb begin
        o_out.valid     = r_act;
        o_out.last      = is_last;
        o_out.character = (r_idx < r_num.first) ? ASCII_SPACE
                        : ASCII_ZERO + CHAR_W'(r_num.dig[r_idx]);
    end

    always_comb begin
        n_act = r_act;
        if (o_load) begin
            n_act = 1'b1;
        end else if (send && is_last) begin
            n_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_num <= i_res.res;
            r_idx <= i_res.res.padded ? '0 : i_res.res.first;
        end else if (send) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Convert an unsigned number to decimal ASCII characters, most significant
// first, with a last flag on the final character.
// ----------------------------------------------------------------------------
// Order: a transaction passes the front into the job queue, the converter
//   takes it and peels one digit per position, and the emitter then loads
//   the finished digit set. Digit positions: 3, 5 or 10 for the 8, 16 and
//   32-bit size modes. Characters go out one per cycle while the output is ready.
// Reset: synchronous, active low; empties the job queue, the converter and
//   the character sender. No memory needs clearing.
// ----------------------------------------------------------------------------
//
// Structure:
//   front  - accepts a transaction, masks the value to its size mode and
//            derives the digit count and the padding rule
//   queue  - two jobs deep, so the input keeps accepting until it is full while
//            the back end works or the output stalls
//   conv   - divides by ten each cycle with a 32x32 reciprocal multiply,
//            writing digits from the least significant position upward and
//            noting the most significant nonzero position
//   emit   - takes a finished digit set, then sends spaces for leading zeros
//            in padded modes or skips them in the 32-bit mode; a zero value
//            always ends in the single digit '0'
// The converter works on the next number while the emitter sends the
// current one.
module binary_to_decimal_ascii (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bda_in_if.sink    i_in,
    bda_out_if.source o_out
);
    import bda_pkg::*;

    logic      front_valid;
    t_job      front_job;
    logic      front_ready;
    logic      queue_valid;
    t_job      queue_job;
    logic      queue_ready;
    t_conv_out conv_res;
    logic      emit_load;

    // classify the incoming transaction
    bda_front u_front (
        .i_in        (i_in),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    // decouple accept from conversion
    bda_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_job   (front_job),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_job    (queue_job),
        .i_pop_ready  (queue_ready)
    );

    // produce the digit set of one number
    bda_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_ready (queue_ready),
        .o_res       (conv_res),
        .i_load      (emit_load)
    );

    // send the characters
    bda_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (conv_res),
        .o_load  (emit_load),
        .o_out   (o_out)
    );

endmodule
